FILE: hw/rtl/sorted_task_queue_defines.svh
// Assertion macros shared by the sorted task queue modules.
`ifndef SORTED_TASK_QUEUE_DEFINES_SVH
`define SORTED_TASK_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define STQ_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sorted_task_queue: assertion failed");
`define STQ_ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sorted_task_queue: forbidden condition seen");
`else
`define STQ_ASSERT(name, clk, rst_n, prop)
`define STQ_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

FILE: hw/rtl/stq_pkg.sv
`default_nettype none
package stq_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_TASK_WORDS = 2;

	localparam int WORD_W      = 32;
	localparam int NUM_WORDS   = 4;
	localparam int COUNT_OUT_W = 5;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_bus_t;

	// Command codes.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SORTED_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_SELECT  = 1'd1;

	// Datapath operations.
	typedef logic [1:0] op_t;
	localparam op_t OP_NONE = 2'd0;
	localparam op_t OP_PUSH = 2'd1;
	localparam op_t OP_POP  = 2'd2;

	typedef struct packed {
		logic capture;
		logic apply;
		op_t  op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sorted_task_queue.sv
// Sorted task queue: holds up to CAPACITY tasks of TASK_WORDS signed words.
// Commands: raise start with command (0 push, 1 pop) and word_0..word_3; the
// item is taken at a clock edge where start is high and busy is low.
// A push in sorted mode goes before the first held task whose key word is not
// smaller, so pops return the largest key first; in unsorted mode it appends.
// A pop returns the last task. Every item yields one result: done is high for
// one cycle with status, out_word_0..out_word_3 and task_count. The receiver
// cannot hold results off; it must take them in that cycle.
// done rises as busy falls, and the result is taken at the edge where done is
// high. busy is high for one cycle after each accept; no item is taken then.
// The accepting edge registers one key compare per storage cell against the
// new key; the next cycle resolves the insert point over the cell row and
// shifts the cells. Configuration (sorted_mode, key_select) is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the queue
// is idle, as the block does not enforce this. Reset empties the queue,
// selects sorted mode and key word 0; stored words are not cleared.
`default_nettype none
module sorted_task_queue
	import stq_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int TASK_WORDS = DEF_TASK_WORDS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      command,
	input  wire logic signed [WORD_W-1:0]  word_0,
	input  wire logic signed [WORD_W-1:0]  word_1,
	input  wire logic signed [WORD_W-1:0]  word_2,
	input  wire logic signed [WORD_W-1:0]  word_3,
	output logic                           done,
	output logic [STATUS_W-1:0]            status,
	output logic signed [WORD_W-1:0]       out_word_0,
	output logic signed [WORD_W-1:0]       out_word_1,
	output logic signed [WORD_W-1:0]       out_word_2,
	output logic signed [WORD_W-1:0]       out_word_3,
	output logic [COUNT_OUT_W-1:0]         task_count
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	word_bus_t in_words;
	word_bus_t out_words;

	assign in_words[0] = word_0;
	assign in_words[1] = word_1;
	assign in_words[2] = word_2;
	assign in_words[3] = word_3;

	stq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.busy    (busy),
		.done    (done),
		.status  (status),
		.cmd     (cmd)
	);

	stq_datapath #(
		.CAPACITY   (CAPACITY),
		.TASK_WORDS (TASK_WORDS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.in_words   (in_words),
		.stat       (stat),
		.out_words  (out_words),
		.task_count (task_count)
	);

	assign out_word_0 = out_words[0];
	assign out_word_1 = out_words[1];
	assign out_word_2 = out_words[2];
	assign out_word_3 = out_words[3];

endmodule
`default_nettype wire

FILE: hw/rtl/stq_ctrl.sv
`default_nettype none
`include "sorted_task_queue_defines.svh"
module stq_ctrl
	import stq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                command,
	input  wire dp_stat_t            stat,
	output logic                     busy,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output ctrl_cmd_t                cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                state_q;
	logic                command_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_d;
	op_t                 op_d;

	assign busy = (state_q == S_EXEC);

	always_comb begin
		op_d     = OP_NONE;
		status_d = ST_DONE;
		if (command_q == CMD_POP) begin
			if (stat.empty) begin
				status_d = ST_EMPTY;
			end else begin
				op_d = OP_POP;
			end
		end else begin
			if (stat.full) begin
				status_d = ST_FULL;
			end else begin
				op_d = OP_PUSH;
			end
		end
	end

	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.apply   = (state_q == S_EXEC);
	assign cmd.op      = (state_q == S_EXEC) ? op_d : OP_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= command;
		end
		if (cmd.apply) begin
			status_q <= status_d;
		end
	end

	assign done   = done_q;
	assign status = status_q;

	`STQ_ASSERT(a_done_follows_exec, clk, arst_n, (state_q == S_EXEC) |=> done_q)
	`STQ_ASSERT(a_done_single_cycle, clk, arst_n, done_q |=> !done_q)
	`STQ_ASSERT(a_no_op_on_failure, clk, arst_n,
		(cmd.apply && status_d != ST_DONE) |-> (cmd.op == OP_NONE))

endmodule
`default_nettype wire

FILE: hw/rtl/stq_datapath.sv
`default_nettype none
`include "sorted_task_queue_defines.svh"
module stq_datapath
	import stq_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int TASK_WORDS = DEF_TASK_WORDS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire ctrl_cmd_t              cmd,
	input  wire word_bus_t              in_words,
	output dp_stat_t                    stat,
	output word_bus_t                   out_words,
	output logic [COUNT_OUT_W-1:0]      task_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (TASK_WORDS > 1) ? $clog2(TASK_WORDS) : 1;

	logic                sorted_mode_q;
	logic [1:0]          key_select_q;
	logic [CW-1:0]       count_q;
	logic [KW-1:0]       key_idx;
	word_t               key_in;
	word_t               task_q [TASK_WORDS];
	word_t               cell_q [CAPACITY][TASK_WORDS];
	logic [CAPACITY-1:0] ge_d;
	logic [CAPACITY-1:0] ge_s1;
	logic [CAPACITY-1:0] above;
	word_bus_t           pop_words;
	word_bus_t           out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_mode_q <= 1'b1;
			key_select_q  <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SORTED_MODE: sorted_mode_q <= cfg_data[0];
				REG_KEY_SELECT:  key_select_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// A key word beyond the task falls back to word 0.
	assign key_idx = ({1'b0, key_select_q} < 3'(TASK_WORDS)) ? KW'(key_select_q) : '0;
	assign key_in  = word_t'(in_words[2'(key_idx)]);

	// Cell 0 holds the last task; higher cells hold earlier tasks.
	for (genvar c = 0; c < CAPACITY; c++) begin : g_cmp
		assign ge_d[c]  = sorted_mode_q && (CW'(c) < count_q)
			&& (cell_q[c][key_idx] >= key_in);
		assign above[c] = |(ge_s1 >> c);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ge_s1 <= ge_d;
			for (int w = 0; w < TASK_WORDS; w++) begin
				task_q[w] <= word_t'(in_words[w]);
			end
		end
	end

	// A push keeps every cell at or below the topmost not-smaller key, drops the
	// new task just above it and moves the rest up; a pop moves all cells down.
	for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
		word_t from_below [TASK_WORDS];
		word_t from_above [TASK_WORDS];
		logic  ins_edge;

		if (c == 0) begin : g_bottom
			assign ins_edge   = 1'b1;
			assign from_below = task_q;
		end else begin : g_inner
			assign ins_edge   = above[c-1];
			assign from_below = cell_q[c-1];
		end

		if (c == CAPACITY - 1) begin : g_top
			assign from_above = cell_q[c];
		end else begin : g_mid
			assign from_above = cell_q[c+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.apply) begin
				unique case (cmd.op)
					OP_PUSH: begin
						if (!above[c]) begin
							cell_q[c] <= ins_edge ? task_q : from_below;
						end
					end
					OP_POP:  cell_q[c] <= from_above;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			unique case (cmd.op)
				OP_PUSH: count_q <= count_q + CW'(1);
				OP_POP:  count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	for (genvar w = 0; w < NUM_WORDS; w++) begin : g_out
		if (w < TASK_WORDS) begin : g_used
			assign pop_words[w] = cell_q[0][w];
		end else begin : g_unused
			assign pop_words[w] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			out_q <= (cmd.op == OP_POP) ? pop_words : '0;
		end
	end

	assign stat.full  = (count_q == CW'(CAPACITY));
	assign stat.empty = (count_q == '0);
	assign out_words  = out_q;
	assign task_count = COUNT_OUT_W'(count_q);

	`STQ_ASSERT_NEVER(a_count_in_range, clk, arst_n, count_q > CW'(CAPACITY))
	`STQ_ASSERT(a_pop_decrements, clk, arst_n,
		(cmd.apply && cmd.op == OP_POP) |=> (count_q == $past(count_q) - CW'(1)))
	`STQ_ASSERT(a_no_push_when_full, clk, arst_n,
		(cmd.apply && stat.full) |-> (cmd.op != OP_PUSH))

endmodule
`default_nettype wire

FILE: tb/sorted_task_queue_test.sv
`default_nettype none
module sorted_task_queue_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stq_pkg::*;

	localparam int CAPACITY   = DEF_CAPACITY;
	localparam int TASK_WORDS = DEF_TASK_WORDS;
	localparam int PHASES     = 8;

	typedef struct packed {
		logic      command;
		word_bus_t words;
	} task_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		word_bus_t              words;
		logic [COUNT_OUT_W-1:0] count;
	} task_result_t;

	logic                   clk;
	logic                   arst_n     = 1'b0;
	logic                   cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index  = REG_SORTED_MODE;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                   start      = 1'b0;
	logic                   command    = CMD_PUSH;
	word_t                  word_0     = '0;
	word_t                  word_1     = '0;
	word_t                  word_2     = '0;
	word_t                  word_3     = '0;
	logic                   busy;
	logic                   done;
	logic [STATUS_W-1:0]    status;
	word_t                  out_word_0;
	word_t                  out_word_1;
	word_t                  out_word_2;
	word_t                  out_word_3;
	logic [COUNT_OUT_W-1:0] task_count;

	task_cmd_t    task_cmds[$];
	task_result_t awaited_results[$];

	// Shadow copy of the queue contents and configuration.
	word_t       model_tasks [CAPACITY][TASK_WORDS];
	int          model_count   = 0;
	logic        model_sorted  = 1'b1;
	logic [1:0]  model_key_sel = 2'd0;

	bit          took_item    = 1'b0;
	bit          steady       = 1'b0;
	int unsigned gap_pct      = 30;
	int unsigned gap_left     = 0;
	int unsigned mismatch_count = 0;

	sorted_task_queue #(
		.CAPACITY   (CAPACITY),
		.TASK_WORDS (TASK_WORDS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.word_0     (word_0),
		.word_1     (word_1),
		.word_2     (word_2),
		.word_3     (word_3),
		.done       (done),
		.status     (status),
		.out_word_0 (out_word_0),
		.out_word_1 (out_word_1),
		.out_word_2 (out_word_2),
		.out_word_3 (out_word_3),
		.task_count (task_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic task_result_t apply_command(task_cmd_t c);
		task_result_t r;
		int           key;
		int           pos;
		word_t        new_key;
		r = '0;
		if (c.command == CMD_PUSH) begin
			if (model_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				key = (model_key_sel < TASK_WORDS) ? model_key_sel : 0;
				new_key = c.words[key];
				pos = model_count;
				if (model_sorted) begin
					for (int k = 0; k < model_count; k++)
						if (pos == model_count && model_tasks[k][key] >= new_key)
							pos = k;
					for (int k = model_count; k > pos; k--)
						model_tasks[k] = model_tasks[k-1];
				end
				for (int w = 0; w < TASK_WORDS; w++)
					model_tasks[pos][w] = c.words[w];
				model_count++;
				r.status = ST_DONE;
			end
		end else begin
			if (model_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				model_count--;
				for (int w = 0; w < TASK_WORDS; w++)
					r.words[w] = model_tasks[model_count][w];
				r.status = ST_DONE;
			end
		end
		r.count = model_count[COUNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic word_t rand_word(bit narrow);
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 6))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return 32'sh0000_0000;
				3: return -32'sd1;
				4: return 32'sd1;
				5: return 32'sh0001_0000;
				default: return -32'sh0001_0000;
			endcase
		end
		if (narrow && pick < 7)
			return word_t'($urandom_range(0, 6)) - 32'sd3;
		return word_t'($urandom);
	endfunction

	function automatic task_cmd_t push_item(word_t key_word);
		task_cmd_t c;
		c.command = CMD_PUSH;
		for (int w = 0; w < NUM_WORDS; w++)
			c.words[w] = word_t'($urandom);
		c.words[0] = key_word;
		return c;
	endfunction

	function automatic task_cmd_t pop_item();
		task_cmd_t c;
		c.command = CMD_POP;
		for (int w = 0; w < NUM_WORDS; w++)
			c.words[w] = word_t'($urandom);
		return c;
	endfunction

	// Sender: a new item goes out once the previous one was taken.
	always @(negedge clk) begin
		task_cmd_t cur;
		if (arst_n && (!start || took_item)) begin
			if (took_item && !steady && $urandom_range(1, 100) <= gap_pct)
				gap_left = $urandom_range(1, 19);
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (task_cmds.size() > 0) begin
				cur = task_cmds.pop_front();
				start   <= 1'b1;
				command <= cur.command;
				word_0  <= cur.words[0];
				word_1  <= cur.words[1];
				word_2  <= cur.words[2];
				word_3  <= cur.words[3];
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		task_result_t got;
		task_result_t want;
		task_cmd_t    taken;
		if (arst_n) begin
			if (done) begin
				got.status   = status;
				got.words[0] = out_word_0;
				got.words[1] = out_word_1;
				got.words[2] = out_word_2;
				got.words[3] = out_word_3;
				got.count    = task_count;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: status %0d, task_count %0d", got.status, got.count);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatch_count++;
					end
					for (int w = 0; w < NUM_WORDS; w++)
						if (got.words[w] !== want.words[w]) begin
							$error("out_word_%0d: expected %h, got %h", w,
								want.words[w], got.words[w]);
							mismatch_count++;
						end
					if (got.count !== want.count) begin
						$error("task_count: expected %0d, got %0d", want.count, got.count);
						mismatch_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SORTED_MODE: model_sorted = cfg_data[0];
					REG_KEY_SELECT:  model_key_sel = cfg_data;
					default: ;
				endcase
			end
			took_item = start && !busy;
			if (took_item) begin
				taken.command = command;
				taken.words[0] = word_0;
				taken.words[1] = word_1;
				taken.words[2] = word_2;
				taken.words[3] = word_3;
				awaited_results.push_back(apply_command(taken));
			end
		end
	end

	task automatic wait_idle();
		bit idle;
		idle = 1'b0;
		while (!idle) begin
			@(posedge clk);
			#1;
			idle = (task_cmds.size() == 0) && !start && (awaited_results.size() == 0);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Runs of pushes and pops with a per-run bias, so the queue keeps
	// swinging between empty and full.
	task automatic queue_phase(int unsigned n_items);
		int unsigned left;
		int unsigned run;
		int unsigned push_pct;
		bit          narrow;
		left = n_items;
		while (left > 0) begin
			run = $urandom_range(8, 40);
			if (run > left)
				run = left;
			case ($urandom_range(0, 3))
				0: push_pct = 20;
				1: push_pct = 50;
				2: push_pct = 80;
				default: push_pct = 95;
			endcase
			narrow = $urandom_range(0, 1);
			repeat (run) begin
				if ($urandom_range(1, 100) <= push_pct)
					task_cmds.push_back(push_item(rand_word(narrow)));
				else
					task_cmds.push_back(pop_item());
			end
			left -= run;
		end
	endtask

	initial begin
		bit          ph_sorted [PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1};
		logic [1:0]  ph_key    [PHASES] = '{2'd0, 2'd0, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1};
		int unsigned ph_gap    [PHASES] = '{30, 50, 0, 30, 70, 30, 40, 0};
		task_cmd_t   c;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty pop, extreme and tied keys, fill to capacity, a push
		// on the full queue, then a few pops.
		task_cmds.push_back(pop_item());
		task_cmds.push_back(push_item(32'sh0000_0000));
		task_cmds.push_back(push_item(32'sh7FFF_FFFF));
		task_cmds.push_back(push_item(32'sh8000_0000));
		task_cmds.push_back(push_item(-32'sd1));
		task_cmds.push_back(push_item(32'sd1));
		task_cmds.push_back(push_item(32'sh0000_0000));
		task_cmds.push_back(push_item(32'sh0001_0000));
		task_cmds.push_back(push_item(-32'sh0001_0000));
		task_cmds.push_back(push_item(32'sh7FFF_FFFF));
		task_cmds.push_back(push_item(32'sh8000_0000));
		for (int i = 0; i < 6; i++)
			task_cmds.push_back(push_item(rand_word(1'b1)));
		c = push_item(word_t'($urandom));
		task_cmds.push_back(c);
		for (int i = 0; i < 5; i++)
			task_cmds.push_back(pop_item());

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_reg(REG_SORTED_MODE, {$urandom_range(0, 1) == 1, ph_sorted[p]});
			write_reg(REG_KEY_SELECT, ph_key[p]);
			gap_pct = ph_gap[p];
			steady = (p == PHASES - 1);
			queue_phase(160);
		end

		wait_idle();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
